/* sv/ggcp_pkg.sv */
// ----------------------------------------------------------------------------
// ggcp_pkg
// Shared types and constants for the greedy graph core placement block.
// ----------------------------------------------------------------------------
package ggcp_pkg;

    localparam int MAX_NODES   = 32;
    localparam int MAX_EDGES   = 64;
    localparam int MAX_WORKERS = 4;

    localparam int NODE_W  = 5;
    localparam int EIDX_W  = 6;
    localparam int ECNT_W  = 7;
    localparam int CORE_W  = 3;
    localparam int WID_W   = 2;
    localparam int LOAD_W  = 6;
    localparam int SLOT_W  = 5;
    localparam int CROSS_W = 7;
    localparam int WCNT_W  = 3;
    localparam int PCNT_W  = 6;
    localparam int ENDS_W  = 2 * NODE_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CORE_W-1:0]  CORE_SINK = 3'd4;
    localparam logic [CORE_W-1:0]  CORE_NONE = 3'd5;
    localparam logic [SLOT_W-1:0]  SLOT_MAX  = 5'd31;
    localparam logic [LOAD_W-1:0]  LOAD_MAX  = 6'd63;
    localparam logic [CROSS_W-1:0] CROSS_MAX = 7'd127;

    typedef enum logic [1:0] {
        MODE_CLEAR    = 2'd0,
        MODE_EDGE     = 2'd1,
        MODE_PLACE    = 2'd2,
        MODE_CLASSIFY = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORKER_COUNT = 1'b0,
        CFG_PLUGIN_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FOLLOW,
        S_PLACE,
        S_C3_EDGE,
        S_C3_FROM,
        S_C3_TO,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_plan;
        logic load_edge;
        logic place_sink;
        logic scan_start;
        logic scan_step;
        logic follow_chk;
        logic place;
        logic c3_rd_edge;
        logic c3_rd_from;
        logic c3_rd_to;
        logic c3_eval;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  is_sink;
        logic  hit;
        logic  scan_done;
        logic  up_on_worker;
        logic  out_free;
    } t_dp_stat;

endpackage

/* sv/ggcp_dp.sv */
// ----------------------------------------------------------------------------
// ggcp_dp
// Datapath: edge table, placement map, worker loads, share cap and result
// registers, driven step by step by the controller.
// ----------------------------------------------------------------------------
module ggcp_dp
    import ggcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mode                 i_mode,
    input  logic [NODE_W-1:0]     i_node_id,
    input  logic                  i_is_sink,
    input  logic [EIDX_W-1:0]     i_edge_index,
    input  logic                  i_edge_used,
    input  logic [NODE_W-1:0]     i_edge_from,
    input  logic [NODE_W-1:0]     i_edge_to,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CORE_W-1:0]     o_core,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_crosses,
    output logic [CROSS_W-1:0]    o_cross_total
);

    // Captured item
    t_mode               r_mode;
    logic [NODE_W-1:0]   r_node;
    logic                r_sink;
    logic [EIDX_W-1:0]   r_eidx;
    logic                r_used;
    logic [NODE_W-1:0]   r_from;
    logic [NODE_W-1:0]   r_to;

    // Configuration and plan state
    logic [WCNT_W-1:0]   r_worker_count;
    logic [PCNT_W-1:0]   r_plugin_count;
    logic [LOAD_W-1:0]   r_cap;
    logic [CROSS_W-1:0]  r_cross_count;
    logic [LOAD_W-1:0]   r_load [MAX_WORKERS];

    // Edge table and placement map
    logic [ENDS_W-1:0]   r_edge_mem [MAX_EDGES];
    logic [MAX_EDGES-1:0] r_edge_vld;
    logic [ENDS_W-1:0]   r_edata;
    logic                r_evld;
    logic [CORE_W-1:0]   r_core_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_core_vld;
    logic [CORE_W-1:0]   r_cdata;

    // Scan control
    logic [ECNT_W-1:0]   r_ecnt;
    logic [EIDX_W-1:0]   r_pidx;
    logic                r_pv;
    logic                r_follow;
    logic [WID_W-1:0]    r_up;
    logic [CORE_W-1:0]   r_cf;

    // Result of the current item, then the output register
    logic [CORE_W-1:0]   r_core;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_crosses;
    logic                r_out_valid;
    logic [CORE_W-1:0]   r_out_core;
    logic [SLOT_W-1:0]   r_out_slot;
    logic                r_out_crosses;
    logic [CROSS_W-1:0]  r_out_total;

    logic                hit;
    logic                scan_more;
    logic                edge_rd_en;
    logic [EIDX_W-1:0]   edge_rd_addr;
    logic                core_rd_en;
    logic [NODE_W-1:0]   core_rd_addr;
    logic                core_wr_en;
    logic [CORE_W-1:0]   core_wr_data;
    logic [WCNT_W-1:0]   w_eff;
    logic [WID_W-1:0]    least;
    logic [WID_W-1:0]    pick;
    logic [WID_W-1:0]    load_idx;
    logic [LOAD_W-1:0]   load_sel;
    logic [ECNT_W-1:0]   cap_sum;
    logic [14:0]         cap_prod;
    logic [ECNT_W-1:0]   cap_q;
    logic [LOAD_W-1:0]   cap_new;
    logic                cross_now;

    assign hit       = r_pv && r_evld && (r_edata[NODE_W-1:0] == r_node);
    assign scan_more = (r_ecnt != ECNT_W'(MAX_EDGES));

    always_comb begin
        if (r_worker_count == '0) begin
            w_eff = WCNT_W'(1);
        end else if (r_worker_count > WCNT_W'(MAX_WORKERS)) begin
            w_eff = WCNT_W'(MAX_WORKERS);
        end else begin
            w_eff = r_worker_count;
        end
    end

    // Share cap: ceil(plugins / workers), at least one, with workers in one to four.
    always_comb begin
        cap_sum  = ECNT_W'(r_plugin_count) + ECNT_W'(w_eff) - ECNT_W'(1);
        cap_prod = 15'(cap_sum) * 15'(171);
        case (w_eff)
            3'd2:    cap_q = cap_sum >> 1;
            3'd3:    cap_q = {1'b0, cap_prod[14:9]};
            3'd4:    cap_q = cap_sum >> 2;
            default: cap_q = cap_sum;
        endcase
        cap_new = (cap_q == '0) ? LOAD_W'(1) : cap_q[LOAD_W-1:0];
    end

    // Least-loaded worker among those in use, ties to the lowest index.
    always_comb begin
        least = '0;
        for (int k = 1; k < MAX_WORKERS; k++) begin
            if ((WCNT_W'(k) < w_eff) && (r_load[k] < r_load[least])) begin
                least = WID_W'(k);
            end
        end
    end

    assign pick     = r_follow ? r_up : least;
    assign load_idx = i_cmd.follow_chk ? r_cdata[WID_W-1:0] : pick;
    assign load_sel = r_load[load_idx];

    assign edge_rd_en   = (i_cmd.scan_step && !hit && scan_more) || i_cmd.c3_rd_edge;
    assign edge_rd_addr = i_cmd.c3_rd_edge ? r_eidx : r_ecnt[EIDX_W-1:0];
    assign core_rd_en   = (i_cmd.scan_step && hit) || i_cmd.c3_rd_from || i_cmd.c3_rd_to;
    assign core_rd_addr = i_cmd.c3_rd_to ? r_edata[NODE_W-1:0]
                                         : r_edata[ENDS_W-1:NODE_W];
    assign core_wr_en   = i_cmd.place_sink || i_cmd.place;
    assign core_wr_data = i_cmd.place_sink ? CORE_SINK : CORE_W'(pick);

    assign cross_now = r_evld && (r_cf != r_cdata);

    // Memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_edge) begin
            r_edge_mem[r_eidx] <= {r_from, r_to};
        end
        if (edge_rd_en) begin
            r_edata <= r_edge_mem[edge_rd_addr];
            r_evld  <= r_edge_vld[edge_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_wr_en) begin
            r_core_mem[r_node] <= core_wr_data;
        end
        if (core_rd_en) begin
            r_cdata <= r_core_vld[core_rd_addr] ? r_core_mem[core_rd_addr] : CORE_NONE;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_node <= i_node_id;
            r_sink <= i_is_sink;
            r_eidx <= i_edge_index;
            r_used <= i_edge_used;
            r_from <= i_edge_from;
            r_to   <= i_edge_to;
        end
        if (i_cmd.scan_step && !hit && scan_more) begin
            r_pidx <= r_ecnt[EIDX_W-1:0];
        end
        if (i_cmd.follow_chk) begin
            r_up <= r_cdata[WID_W-1:0];
        end
        if (i_cmd.c3_rd_to) begin
            r_cf <= r_cdata;
        end
        if (i_cmd.clear_plan || i_cmd.load_edge) begin
            r_core    <= CORE_NONE;
            r_slot    <= '0;
            r_crosses <= 1'b0;
        end
        if (i_cmd.place_sink) begin
            r_core    <= CORE_SINK;
            r_slot    <= '0;
            r_crosses <= 1'b0;
        end
        if (i_cmd.place) begin
            r_core    <= CORE_W'(pick);
            r_slot    <= load_sel[LOAD_W-1] ? SLOT_MAX : load_sel[SLOT_W-1:0];
            r_crosses <= 1'b0;
        end
        if (i_cmd.c3_eval) begin
            r_core    <= CORE_NONE;
            r_slot    <= '0;
            r_crosses <= cross_now;
        end
        if (i_cmd.load_out) begin
            r_out_core    <= r_core;
            r_out_slot    <= r_slot;
            r_out_crosses <= r_crosses;
            r_out_total   <= r_cross_count;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker_count <= WCNT_W'(1);
            r_plugin_count <= '0;
            r_cap          <= LOAD_W'(1);
            r_cross_count  <= '0;
            r_edge_vld     <= '0;
            r_core_vld     <= '0;
            r_ecnt         <= '0;
            r_pv           <= 1'b0;
            r_follow       <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < MAX_WORKERS; k++) begin
                r_load[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_WORKER_COUNT: r_worker_count <= i_cfg_wdata[WCNT_W-1:0];
                    CFG_PLUGIN_COUNT: r_plugin_count <= i_cfg_wdata[PCNT_W-1:0];
                endcase
            end
            if (i_cmd.clear_plan) begin
                r_cap         <= cap_new;
                r_cross_count <= '0;
                r_core_vld    <= '0;
                for (int k = 0; k < MAX_WORKERS; k++) begin
                    r_load[k] <= '0;
                end
            end
            if (i_cmd.load_edge) begin
                r_edge_vld[r_eidx] <= r_used;
            end
            if (core_wr_en) begin
                r_core_vld[r_node] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_ecnt   <= '0;
                r_pv     <= 1'b0;
                r_follow <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (hit) begin
                    // Resume after the matching slot if its producer is not followed.
                    r_pv   <= 1'b0;
                    r_ecnt <= ECNT_W'(r_pidx) + ECNT_W'(1);
                end else if (scan_more) begin
                    r_pv   <= 1'b1;
                    r_ecnt <= r_ecnt + ECNT_W'(1);
                end else begin
                    r_pv <= 1'b0;
                end
            end
            if (i_cmd.follow_chk && o_stat.up_on_worker) begin
                r_follow <= (load_sel < r_cap);
            end
            if (i_cmd.place && (load_sel != LOAD_MAX)) begin
                r_load[pick] <= load_sel + LOAD_W'(1);
            end
            if (i_cmd.c3_eval && cross_now && (r_cdata != CORE_SINK)
                    && (r_cross_count != CROSS_MAX)) begin
                r_cross_count <= r_cross_count + CROSS_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.mode         = r_mode;
        o_stat.is_sink      = r_sink;
        o_stat.hit          = hit;
        o_stat.scan_done    = !r_pv && !scan_more;
        o_stat.up_on_worker = (r_cdata < CORE_W'(MAX_WORKERS));
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_core        = r_out_core;
    assign o_slot        = r_out_slot;
    assign o_crosses     = r_out_crosses;
    assign o_cross_total = r_out_total;

endmodule

/* sv/ggcp_ctrl.sv */
// ----------------------------------------------------------------------------
// ggcp_ctrl
// Controller: sequences each item's steps through the datapath.
// ----------------------------------------------------------------------------
module ggcp_ctrl
    import ggcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // The input side stays closed while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.mode)
                    MODE_CLEAR: begin
                        o_cmd.clear_plan = 1'b1;
                        n_state          = S_RESP;
                    end
                    MODE_EDGE: begin
                        o_cmd.load_edge = 1'b1;
                        n_state         = S_RESP;
                    end
                    MODE_PLACE: begin
                        if (i_stat.is_sink) begin
                            o_cmd.place_sink = 1'b1;
                            n_state          = S_RESP;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    MODE_CLASSIFY: begin
                        o_cmd.c3_rd_edge = 1'b1;
                        n_state          = S_C3_EDGE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_FOLLOW;
                end else if (i_stat.scan_done) begin
                    n_state = S_PLACE;
                end
            end
            S_FOLLOW: begin
                // A producer on a worker ends the search; sink or unplaced ones are skipped.
                o_cmd.follow_chk = 1'b1;
                n_state = i_stat.up_on_worker ? S_PLACE : S_SCAN;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_RESP;
            end
            S_C3_EDGE: begin
                o_cmd.c3_rd_from = 1'b1;
                n_state          = S_C3_FROM;
            end
            S_C3_FROM: begin
                o_cmd.c3_rd_to = 1'b1;
                n_state        = S_C3_TO;
            end
            S_C3_TO: begin
                o_cmd.c3_eval = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/greedy_graph_core_placement_top.sv */
// ----------------------------------------------------------------------------
// greedy_graph_core_placement_top
// Greedy placement of dataflow graph nodes onto workers, stream interface.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next is accepted as soon as the
// result of the current one sits in the output register, even if that
// result has not yet been taken. Clear, edge load and sink placement go
// straight to the result; classification reads the edge, then the
// producer's and consumer's cores. A non-sink placement scans the 64-slot
// edge table through its single read port, one slot per cycle save for a
// producer lookup at each matching edge, up to a producer on a worker. The
// table and map are tracked by valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module greedy_graph_core_placement_top
    import ggcp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // node_id[4:0], edge_index[10:5], edge_used[11], edge_from[16:12],
    // edge_to[21:17], zero fill [23:22]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // mode[1:0], is_sink[2]
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // core[2:0], slot[7:3], crosses[8], cross_total[15:9]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic [CORE_W-1:0]   out_core;
    logic [SLOT_W-1:0]   out_slot;
    logic                out_crosses;
    logic [CROSS_W-1:0]  out_total;

    ggcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ggcp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (t_mode'(i_s_axis_tuser[1:0])),
        .i_node_id     (i_s_axis_tdata[4:0]),
        .i_is_sink     (i_s_axis_tuser[2]),
        .i_edge_index  (i_s_axis_tdata[10:5]),
        .i_edge_used   (i_s_axis_tdata[11]),
        .i_edge_from   (i_s_axis_tdata[16:12]),
        .i_edge_to     (i_s_axis_tdata[21:17]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_core        (out_core),
        .o_slot        (out_slot),
        .o_crosses     (out_crosses),
        .o_cross_total (out_total)
    );

    assign o_m_axis_tdata = {out_total, out_crosses, out_slot, out_core};

    // Only one item is in work: after a transfer in, the input side closes.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while an item is in work");

    // A result never carries a core code beyond the unplaced marker.
    a_core_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_core <= CORE_NONE))
        else $error("result core code out of range");

    // Only classification raises crosses, and it always reports unplaced.
    a_cross_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && out_crosses |-> (out_core == CORE_NONE))
        else $error("crossing flag on a placement result");

    // A nonzero slot belongs to a node placed on a worker.
    a_slot_worker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (out_slot != '0) |-> (out_core < CORE_W'(MAX_WORKERS)))
        else $error("slot given for a node not on a worker");

endmodule
